// ----- design/ddo_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the odometry block.
package ddo_pkg;

  localparam int COUNT_WIDTH_DEF  = 64;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;

  // Operand widths of the shared multiplier and divider
  localparam int MUL_A_W = 128;
  localparam int MUL_B_W = 64;
  localparam int DIV_N_W = 128;
  localparam int DIV_D_W = 64;
  localparam int ANG_W   = 34;

  localparam logic [127:0]          TRAVEL_MAX   = 128'h7FFF_FFFF_FFFF;
  localparam logic [63:0]           BAM_SCALE    = 64'd2935890503282001226;
  localparam logic signed [ANG_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [63:0]           RATE_MUL     = 64'd5625;
  localparam logic [63:0]           SPEED_MUL    = 64'd1000;
  localparam int                    RATE_SHIFT   = 42;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_LEFT_SCALE  = 3'd0;
  localparam cfg_index_t CFG_RIGHT_SCALE = 3'd1;
  localparam cfg_index_t CFG_LEFT_REV    = 3'd2;
  localparam cfg_index_t CFG_RIGHT_REV   = 3'd3;
  localparam cfg_index_t CFG_TRACK       = 3'd4;
  localparam cfg_index_t CFG_PERIOD      = 3'd5;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_POSE   = 1'b1;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_ERROR  = 2'd2;

  localparam logic [1:0] EV_BASE  = 2'd0;
  localparam logic [1:0] EV_INTEG = 2'd1;
  localparam logic [1:0] EV_FAIL  = 2'd2;
  localparam logic [1:0] EV_POSE  = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic               sample_ok;
    logic signed [63:0] left_count;
    logic signed [63:0] right_count;
    logic signed [31:0] new_x_mm;
    logic signed [31:0] new_y_mm;
    logic signed [31:0] new_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x_mm;
    logic signed [31:0] pos_y_mm;
    logic signed [31:0] heading;
    logic signed [31:0] speed_mm_s;
    logic signed [31:0] turn_rate;
    logic [1:0]         odo_mode;
    logic [1:0]         event_res;
  } out_item_t;

  // atan(2^-i) as a binary angle
  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Apply sign to a magnitude, saturating to int32
  function automatic logic [31:0] sat32(input logic [127:0] mag, input logic neg);
    logic big;
    big = |mag[127:31];
    if (neg) begin
      return big ? 32'h80000000 : 32'd0 - mag[31:0];
    end
    return big ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end
    if (v < -64'sh0000_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage

// ----- design/ddo_mul.sv -----
`timescale 1ns / 1ps
// Shared multiplier: 128 x 64 product built from 32 x 32 partial products.
module ddo_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  import ddo_pkg::*;

  localparam int B_WORDS = MUL_B_W / 32;
  localparam int N_PROD  = (MUL_A_W / 32) * B_WORDS;

  logic [3:0]   k;
  logic         busy;
  logic         pv;
  logic [63:0]  p;
  logic [2:0]   sh;
  logic [127:0] acc;
  logic [1:0]   wi;
  logic         wj;
  logic [31:0]  a_w;
  logic [31:0]  b_w;
  logic         issue;

  assign wi    = k[2:1];
  assign wj    = k[0];
  assign a_w   = a[32*wi +: 32];
  assign b_w   = b[32*wj +: 32];
  assign issue = busy && (k != 4'(N_PROD));
  assign prod  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pv   <= 1'b0;
        k    <= '0;
      end else if (busy) begin
        pv <= issue;
        if (issue) begin
          k <= k + 4'd1;
        end
        if (!issue && pv) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Register each partial product and accumulate it in the cycle after
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (busy && pv) begin
      acc <= acc + (128'(p) << {sh, 5'd0});
    end
    if (issue) begin
      p  <= a_w * b_w;
      sh <= 3'(wi) + 3'(wj);
    end
  end

endmodule

// ----- design/ddo_div.sv -----
`timescale 1ns / 1ps
// Shared restoring divider: 128-bit dividend, 64-bit divisor, one bit a cycle.
module ddo_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic [127:0] quot,
  output logic         done
);
  import ddo_pkg::*;

  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] nq;
  logic [6:0]         cnt;
  logic               busy;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               fits;

  assign trial = {rem, nq[DIV_N_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};
  assign quot  = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nq  <= num;
    end else if (busy) begin
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      nq  <= {nq[DIV_N_W-2:0], fits};
    end
  end

endmodule

// ----- design/ddo_cordic.sv -----
`timescale 1ns / 1ps
// Iterative CORDIC rotation giving cos and sin of a binary angle.
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [31:0]                     angle,
  output logic signed [ddo_pkg::ANG_W-1:0] cos_val,
  output logic signed [ddo_pkg::ANG_W-1:0] sin_val,
  output logic                            done
);
  import ddo_pkg::*;

  localparam int STEP_W = $clog2(STEPS);

  logic signed [ANG_W-1:0] x;
  logic signed [ANG_W-1:0] y;
  logic signed [ANG_W-1:0] z;
  logic signed [ANG_W-1:0] dx;
  logic signed [ANG_W-1:0] dy;
  logic signed [ANG_W-1:0] at;
  logic                    flip;
  logic                    flip_c;
  logic [31:0]             ang_r;
  logic [STEP_W-1:0]       i;
  logic                    busy;

  // Fold the back half-plane onto the front one
  assign flip_c = (angle > 32'h40000000) && (angle < 32'hC0000000);
  assign ang_r  = flip_c ? angle + 32'h80000000 : angle;
  assign dx     = y >>> i;
  assign dy     = x >>> i;
  assign at     = signed'(ANG_W'(atan_step(5'(i))));
  assign cos_val = flip ? -x : x;
  assign sin_val = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_START;
      y    <= '0;
      z    <= ANG_W'(signed'(ang_r));
      flip <= flip_c;
    end else if (busy) begin
      if (!z[ANG_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

endmodule

// ----- design/diff_drive_odometry_unit.sv -----
`timescale 1ns / 1ps
// Pose, baseline and failed items go from S_IDLE straight to S_FIN, which raises out_valid once the output is free.
// An integrated sample takes three passes of the shared divider, seven runs of the shared
// multiplier, a run of the CORDIC, the S_SUM step to form the sum and difference, and S_FIN
// to hand over the result.
// One item at a time; the next item is taken while a result still waits at the output.
// Reset (rst, synchronous) loads register defaults, clears pose, baseline and mode.
module diff_drive_odometry_unit #(
  parameter int COUNT_WIDTH  = ddo_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddo_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ddo_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ddo_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import ddo_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_TRAV_L   = 14'h0002,
    S_TRAV_R   = 14'h0004,
    S_SUM      = 14'h0008,
    S_YAW_MUL  = 14'h0010,
    S_YAW_DIV  = 14'h0020,
    S_CORDIC   = 14'h0040,
    S_POS_X    = 14'h0080,
    S_POS_Y    = 14'h0100,
    S_SPD_MUL  = 14'h0200,
    S_SPD_DIV  = 14'h0400,
    S_RATE_MUL = 14'h0800,
    S_RATE_DIV = 14'h1000,
    S_FIN      = 14'h2000
  } state_t;

  state_t state;
  logic   issued;

  // configuration
  logic [31:0] left_scale;
  logic [31:0] right_scale;
  logic        left_rev;
  logic        right_rev;
  logic [31:0] track;
  logic [9:0]  period;

  // odometry state
  logic                   base_valid;
  logic [COUNT_WIDTH-1:0] base_left;
  logic [COUNT_WIDTH-1:0] base_right;
  logic [31:0]            elapsed;
  logic signed [47:0]     acc_x;
  logic signed [47:0]     acc_y;
  logic [31:0]            heading_acc;
  logic [31:0]            speed_reg;
  logic [31:0]            rate_reg;
  logic [1:0]             mode_reg;

  // per-item working registers
  logic [COUNT_WIDTH-1:0] cnt_l;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   l_neg;
  logic [46:0]            l_mag;
  logic                   r_neg;
  logic [46:0]            r_mag;
  logic                   sneg;
  logic [47:0]            smag;
  logic                   dneg;
  logic [47:0]            dmag;
  logic [127:0]           q_reg;
  logic [1:0]             ev_reg;

  logic accept;
  logic [32:0] el_sum;
  logic [31:0] el_new;
  logic [1:0]  acc_ev;

  logic [COUNT_WIDTH-1:0] diff_l;
  logic [COUNT_WIDTH-1:0] diff_r;
  logic [COUNT_WIDTH-1:0] mag_l;
  logic [COUNT_WIDTH-1:0] mag_r;
  logic [COUNT_WIDTH-1:0] wheel_mag;
  logic [31:0]            wheel_scale;
  logic                   wheel_neg;
  logic [46:0]            travel;

  logic signed [48:0] l_s;
  logic signed [48:0] r_s;
  logic signed [48:0] sum_s;
  logic signed [48:0] dif_s;

  logic [31:0] turn_s;
  logic [31:0] half_s;

  logic                    mul_start;
  logic                    mul_done;
  logic [127:0]            mul_a;
  logic [63:0]             mul_b;
  logic [127:0]            mul_prod;
  logic                    div_start;
  logic                    div_done;
  logic [127:0]            div_num;
  logic [63:0]             div_den;
  logic [127:0]            div_quot;
  logic                    cor_start;
  logic                    cor_done;
  logic signed [ANG_W-1:0] cos_v;
  logic signed [ANG_W-1:0] sin_v;

  logic signed [ANG_W-1:0] trig;
  logic [ANG_W-1:0]        trig_mag;
  logic                    step_neg;
  logic signed [63:0]      step_s;
  logic signed [47:0]      acc_cur;
  logic signed [47:0]      acc_upd;
  logic [63:0]             spd_num;
  out_item_t               res;

  function automatic logic [31:0] round_pos(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [48:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r   = (49'(mag) + (49'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return sat32(128'(r), v[47]);
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign el_sum = 33'(elapsed) + 33'(period);
  assign el_new = base_valid ? (el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0]) : elapsed;

  always_comb begin
    if (in_item.req_type == REQ_POSE) begin
      acc_ev = EV_POSE;
    end else if (!in_item.sample_ok) begin
      acc_ev = EV_FAIL;
    end else if (!base_valid) begin
      acc_ev = EV_BASE;
    end else if (el_new == 32'd0) begin
      acc_ev = EV_FAIL;
    end else begin
      acc_ev = EV_INTEG;
    end
  end

  // Wrap-safe tick deltas
  assign diff_l = cnt_l - base_left;
  assign diff_r = cnt_r - base_right;
  assign mag_l  = diff_l[COUNT_WIDTH-1] ? '0 - diff_l : diff_l;
  assign mag_r  = diff_r[COUNT_WIDTH-1] ? '0 - diff_r : diff_r;

  assign wheel_mag   = (state == S_TRAV_L) ? mag_l : mag_r;
  assign wheel_scale = (state == S_TRAV_L) ? left_scale : right_scale;
  assign wheel_neg   = (state == S_TRAV_L) ? (diff_l[COUNT_WIDTH-1] ^ left_rev)
                                           : (diff_r[COUNT_WIDTH-1] ^ right_rev);
  assign travel      = (mul_prod > TRAVEL_MAX) ? '1 : mul_prod[46:0];

  assign l_s   = l_neg ? -signed'(49'(l_mag)) : signed'(49'(l_mag));
  assign r_s   = r_neg ? -signed'(49'(r_mag)) : signed'(49'(r_mag));
  assign sum_s = l_s + r_s;
  assign dif_s = l_s - r_s;

  assign turn_s = dneg ? 32'd0 - q_reg[63:32] : q_reg[63:32];
  assign half_s = dneg ? 32'd0 - q_reg[64:33] : q_reg[64:33];

  assign trig     = (state == S_POS_Y) ? sin_v : cos_v;
  assign trig_mag = trig[ANG_W-1] ? ANG_W'(-trig) : ANG_W'(trig);
  assign step_neg = sneg ^ trig[ANG_W-1];
  assign step_s   = step_neg ? -signed'(64'(mul_prod[79:31])) : signed'(64'(mul_prod[79:31]));
  assign acc_cur  = (state == S_POS_Y) ? acc_y : acc_x;
  assign acc_upd  = clamp48(64'(acc_cur) + step_s);

  assign spd_num = mul_prod[63:0] + (64'(elapsed) << FRAC_BITS);

  always_comb begin
    case (state)
      S_TRAV_L, S_TRAV_R: begin
        mul_a = 128'(wheel_mag);
        mul_b = 64'(wheel_scale);
      end
      S_YAW_MUL: begin
        mul_a = 128'(dmag);
        mul_b = BAM_SCALE;
      end
      S_POS_X, S_POS_Y: begin
        mul_a = 128'(smag);
        mul_b = 64'(trig_mag);
      end
      S_SPD_MUL: begin
        mul_a = 128'(smag);
        mul_b = SPEED_MUL;
      end
      S_RATE_MUL: begin
        mul_a = q_reg;
        mul_b = RATE_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_YAW_DIV: begin
        div_num = mul_prod;
        div_den = (track == 32'd0) ? 64'd1 : 64'(track);
      end
      S_SPD_DIV: begin
        div_num = 128'(spd_num);
        div_den = 64'(elapsed) << (FRAC_BITS + 1);
      end
      S_RATE_DIV: begin
        div_num = mul_prod >> RATE_SHIFT;
        div_den = 64'(elapsed);
      end
      default: begin
        div_num = '0;
        div_den = 64'd1;
      end
    endcase
  end

  assign mul_start = !issued && (state == S_TRAV_L || state == S_TRAV_R ||
                     state == S_YAW_MUL || state == S_POS_X || state == S_POS_Y ||
                     state == S_SPD_MUL || state == S_RATE_MUL);
  assign div_start = !issued && (state == S_YAW_DIV || state == S_SPD_DIV ||
                     state == S_RATE_DIV);
  assign cor_start = !issued && (state == S_CORDIC);

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (heading_acc + half_s),
    .cos_val (cos_v),
    .sin_val (sin_v),
    .done    (cor_done)
  );

  always_comb begin
    res.pos_x_mm   = round_pos(acc_x);
    res.pos_y_mm   = round_pos(acc_y);
    res.heading    = heading_acc;
    res.speed_mm_s = speed_reg;
    res.turn_rate  = rate_reg;
    res.odo_mode   = mode_reg;
    res.event_res  = ev_reg;
  end

  // Sequencer and odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issued      <= 1'b0;
      out_valid   <= 1'b0;
      left_scale  <= 32'd65536;
      right_scale <= 32'd65536;
      left_rev    <= 1'b0;
      right_rev   <= 1'b0;
      track       <= 32'd13107200;
      period      <= 10'd10;
      base_valid  <= 1'b0;
      base_left   <= '0;
      base_right  <= '0;
      elapsed     <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      heading_acc <= '0;
      speed_reg   <= '0;
      rate_reg    <= '0;
      mode_reg    <= MODE_IDLE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEFT_SCALE:  left_scale  <= cfg_data;
          CFG_RIGHT_SCALE: right_scale <= cfg_data;
          CFG_LEFT_REV:    left_rev    <= cfg_data[0];
          CFG_RIGHT_REV:   right_rev   <= cfg_data[0];
          CFG_TRACK:       track       <= cfg_data;
          CFG_PERIOD:      period      <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (mul_start || div_start || cor_start) begin
        issued <= 1'b1;
      end
      if (mul_done || div_done || cor_done) begin
        issued <= 1'b0;
      end

      // Hand the result to the output register once it is free
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (acc_ev == EV_INTEG) ? S_TRAV_L : S_FIN;
            if (in_item.req_type == REQ_POSE) begin
              acc_x       <= clamp48(64'(in_item.new_x_mm) <<< FRAC_BITS);
              acc_y       <= clamp48(64'(in_item.new_y_mm) <<< FRAC_BITS);
              heading_acc <= unsigned'(in_item.new_heading);
              speed_reg   <= '0;
              rate_reg    <= '0;
              base_valid  <= 1'b0;
              elapsed     <= '0;
            end else begin
              if (!in_item.sample_ok) begin
                elapsed   <= el_new;
                mode_reg  <= MODE_ERROR;
                speed_reg <= '0;
                rate_reg  <= '0;
              end else if (!base_valid) begin
                mode_reg   <= MODE_ACTIVE;
                speed_reg  <= '0;
                rate_reg   <= '0;
                base_left  <= in_item.left_count[COUNT_WIDTH-1:0];
                base_right <= in_item.right_count[COUNT_WIDTH-1:0];
                elapsed    <= '0;
                base_valid <= 1'b1;
              end else begin
                elapsed <= el_new;
              end
            end
          end
        end
        S_TRAV_L: if (mul_done) state <= S_TRAV_R;
        S_TRAV_R: if (mul_done) state <= S_SUM;
        S_SUM:    state <= S_YAW_MUL;
        S_YAW_MUL: if (mul_done) state <= S_YAW_DIV;
        S_YAW_DIV: if (div_done) state <= S_CORDIC;
        S_CORDIC: begin
          if (cor_done) begin
            heading_acc <= heading_acc + turn_s;
            state       <= S_POS_X;
          end
        end
        S_POS_X: begin
          if (mul_done) begin
            acc_x <= acc_upd;
            state <= S_POS_Y;
          end
        end
        S_POS_Y: begin
          if (mul_done) begin
            acc_y <= acc_upd;
            state <= S_SPD_MUL;
          end
        end
        S_SPD_MUL: if (mul_done) state <= S_SPD_DIV;
        S_SPD_DIV: begin
          if (div_done) begin
            speed_reg <= sat32(div_quot, sneg);
            state     <= S_RATE_MUL;
          end
        end
        S_RATE_MUL: if (mul_done) state <= S_RATE_DIV;
        S_RATE_DIV: begin
          if (div_done) begin
            rate_reg   <= sat32(div_quot, dneg);
            base_left  <= cnt_l;
            base_right <= cnt_r;
            elapsed    <= '0;
            mode_reg   <= MODE_ACTIVE;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_l  <= in_item.left_count[COUNT_WIDTH-1:0];
      cnt_r  <= in_item.right_count[COUNT_WIDTH-1:0];
      ev_reg <= acc_ev;
    end
    if (state == S_TRAV_L && mul_done) begin
      l_mag <= travel;
      l_neg <= wheel_neg;
    end
    if (state == S_TRAV_R && mul_done) begin
      r_mag <= travel;
      r_neg <= wheel_neg;
    end
    if (state == S_SUM) begin
      sneg <= sum_s[48];
      smag <= sum_s[48] ? 48'(-sum_s) : 48'(sum_s);
      dneg <= dif_s[48];
      dmag <= dif_s[48] ? 48'(-dif_s) : 48'(dif_s);
    end
    if (state == S_YAW_DIV && div_done) begin
      q_reg <= div_quot;
    end
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_item <= res;
    end
  end

endmodule

// ----- tb/diff_drive_odometry_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the differential-drive odometry unit.
module diff_drive_odometry_unit_test;
  import ddo_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  logic [31:0] cfg_data;

  diff_drive_odometry_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  localparam logic [31:0] ATAN_BAM [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_8000_0000_0000;

  // Odometry state mirrored by the predictor
  logic [31:0] lscale, rscale, track, period;
  logic        lrev, rrev;
  logic        base_seen;
  logic [63:0] base_l, base_r;
  logic [31:0] elapsed;
  longint      pose_x, pose_y;
  logic [31:0] yaw, speed_q, rate_q;
  logic [1:0]  mode_q;

  out_item_t   expected_pose_q[$];
  int          mismatches;
  int          n_items;
  int          n_results;
  int          n_integrated;
  int          n_cfg;
  bit          idle_on;
  int          hold_cycles;
  logic [63:0] cur_l, cur_r;

  function automatic logic [31:0] sat_int32(logic [127:0] mag, logic neg);
    if (neg) begin
      return (|mag[127:31]) ? 32'h80000000 : 32'd0 - mag[31:0];
    end
    return (|mag[127:31]) ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  function automatic longint acc_clamp(longint v);
    return v > ACC_HI ? ACC_HI : (v < ACC_LO ? ACC_LO : v);
  endfunction

  function automatic logic [31:0] round_mm(longint acc);
    logic [63:0] mag;
    mag = acc < 0 ? 64'(-acc) : 64'(acc);
    mag = (mag + 64'd32768) >> 16;
    return sat_int32({64'd0, mag}, acc < 0);
  endfunction

  function automatic longint wheel_mm(logic [63:0] cnt, logic [63:0] base,
                                      logic [31:0] scale, logic rev);
    logic [63:0]  d;
    logic [63:0]  mag;
    logic         neg;
    logic [127:0] p;
    d = cnt - base;
    neg = d[63];
    mag = neg ? (~d + 64'd1) : d;
    neg = neg ^ rev;
    p = '0;
    if (scale != 0 && mag != 0) begin
      p = {64'd0, mag} * {96'd0, scale};
      if (p > TRAVEL_MAX) p = TRAVEL_MAX;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic void rotate_unit(input logic [31:0] ang, output longint co,
                                      output longint si);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    if (ang > 32'h40000000 && ang < 32'hC0000000) begin
      ang = ang + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_BAM[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_BAM[i]);
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  function automatic longint step_along(logic [63:0] smag, logic sneg, longint trig);
    logic [63:0] b, p;
    b = trig < 0 ? 64'(-trig) : 64'(trig);
    p = (smag >> 31) * b + (((smag & 64'h7FFFFFFF) * b) >> 31);
    return (sneg != (trig < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void integrate_move(in_item_t it);
    longint       tl, tr, sum, dif, co, si;
    logic         sneg, dneg;
    logic [63:0]  smag, dmag, num, den;
    logic [127:0] q, qr;
    logic [31:0]  turn, half;
    tl = wheel_mm(it.left_count, base_l, lscale, lrev);
    tr = wheel_mm(it.right_count, base_r, rscale, rrev);
    sum = tl + tr;
    dif = tl - tr;
    sneg = sum < 0;
    dneg = dif < 0;
    smag = sneg ? 64'(-sum) : 64'(sum);
    dmag = dneg ? 64'(-dif) : 64'(dif);
    q = ({64'd0, dmag} * {64'd0, BAM_SCALE}) / {96'd0, (track != 0 ? track : 32'd1)};
    turn = q[63:32];
    half = q[64:33];
    if (dneg) begin
      turn = 32'd0 - turn;
      half = 32'd0 - half;
    end
    rotate_unit(yaw + half, co, si);
    pose_x = acc_clamp(pose_x + step_along(smag, sneg, co));
    pose_y = acc_clamp(pose_y + step_along(smag, sneg, si));
    yaw = yaw + turn;
    num = smag * 64'd1000 + ({32'd0, elapsed} << 16);
    den = {32'd0, elapsed} << 17;
    speed_q = sat_int32({64'd0, num / den}, sneg);
    qr = q * 128'd5625;
    qr = (qr >> 42) / {96'd0, elapsed};
    rate_q = sat_int32(qr, dneg);
    base_l = it.left_count;
    base_r = it.right_count;
    elapsed = 0;
    mode_q = MODE_ACTIVE;
  endfunction

  function automatic out_item_t predict_pose(in_item_t it);
    out_item_t  r;
    logic [1:0] ev;
    if (it.req_type == REQ_POSE) begin
      pose_x = acc_clamp(longint'(it.new_x_mm) * 65536);
      pose_y = acc_clamp(longint'(it.new_y_mm) * 65536);
      yaw = it.new_heading;
      speed_q = 0;
      rate_q = 0;
      base_seen = 0;
      elapsed = 0;
      ev = EV_POSE;
    end else begin
      if (base_seen) begin
        elapsed = (elapsed > 32'hFFFFFFFF - period) ? 32'hFFFFFFFF : elapsed + period;
      end
      if (!it.sample_ok) begin
        mode_q = MODE_ERROR;
        speed_q = 0;
        rate_q = 0;
        ev = EV_FAIL;
      end else if (!base_seen) begin
        mode_q = MODE_ACTIVE;
        speed_q = 0;
        rate_q = 0;
        base_l = it.left_count;
        base_r = it.right_count;
        elapsed = 0;
        base_seen = 1;
        ev = EV_BASE;
      end else if (elapsed == 0) begin
        ev = EV_FAIL;
      end else begin
        integrate_move(it);
        ev = EV_INTEG;
      end
    end
    r.pos_x_mm = round_mm(pose_x);
    r.pos_y_mm = round_mm(pose_y);
    r.heading = yaw;
    r.speed_mm_s = speed_q;
    r.turn_rate = rate_q;
    r.odo_mode = mode_q;
    r.event_res = ev;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver side: long hold when asked, otherwise random stall bursts while idle_on is set
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1;
        hold_cycles--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_stall = 0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 n_results, name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        e = expected_pose_q.pop_front();
        check_field("pos_x_mm", e.pos_x_mm, out_item.pos_x_mm);
        check_field("pos_y_mm", e.pos_y_mm, out_item.pos_y_mm);
        check_field("heading", e.heading, out_item.heading);
        check_field("speed_mm_s", e.speed_mm_s, out_item.speed_mm_s);
        check_field("turn_rate", e.turn_rate, out_item.turn_rate);
        check_field("odo_mode", 32'(e.odo_mode), 32'(out_item.odo_mode));
        check_field("event_res", 32'(e.event_res), 32'(out_item.event_res));
      end
      n_results++;
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    expected_pose_q.push_back(predict_pose(it));
    if (expected_pose_q[$].event_res == EV_INTEG) n_integrated++;
    n_items++;
  endtask

  // Hold the input idle until every expected result has come back
  task automatic drain;
    @(negedge clk);
    in_valid = 0;
    while (expected_pose_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEFT_SCALE:  lscale = value;
      CFG_RIGHT_SCALE: rscale = value;
      CFG_LEFT_REV:    lrev = value[0];
      CFG_RIGHT_REV:   rrev = value[0];
      CFG_TRACK:       track = value;
      CFG_PERIOD:      period = {22'd0, value[9:0]};
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic in_item_t sample(logic ok, logic [63:0] l, logic [63:0] r);
    in_item_t it;
    it.req_type = REQ_SAMPLE;
    it.sample_ok = ok;
    it.left_count = l;
    it.right_count = r;
    it.new_x_mm = $urandom;
    it.new_y_mm = $urandom;
    it.new_heading = $urandom;
    return it;
  endfunction

  function automatic in_item_t pose(logic [31:0] x, logic [31:0] y, logic [31:0] h);
    in_item_t it;
    it.req_type = REQ_POSE;
    it.sample_ok = $urandom_range(0, 1);
    it.left_count = {$urandom, $urandom};
    it.right_count = {$urandom, $urandom};
    it.new_x_mm = x;
    it.new_y_mm = y;
    it.new_heading = h;
    return it;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'hFFFFFFFF;
      2: return 32'd65536;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  task automatic test_directed;
    send_item(sample(1, 64'd0, 64'd0));
    send_item(sample(1, 64'd100, 64'd100));
    send_item(sample(1, 64'd300, 64'd50));
    send_item(sample(1, 64'd250, 64'd400));
    send_item(sample(0, 64'd999, 64'd999));
    send_item(sample(1, 64'd500, 64'd300));
    // Deltas of 2^47 (left) and exactly half the count range (right) saturate the travel
    send_item(sample(1, 64'h8000_0000_01F4, 64'h8000_0000_0000_012C));
    send_item(sample(1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF));
    send_item(pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_item(sample(1, 64'd0, 64'd0));
    send_item(sample(1, 64'd5000, 64'd0));
    send_item(pose(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send_item(sample(1, 64'd10, 64'd10));
    send_item(sample(1, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0));
    send_item(pose(32'd0, 32'd0, 32'h40000000));
    send_item(sample(1, 64'd0, 64'd0));
    drain();
    // Zero period drops samples; zero scale and zero track go through
    write_reg(CFG_PERIOD, 32'd0);
    send_item(sample(1, 64'd40, 64'd20));
    drain();
    write_reg(CFG_PERIOD, 32'd1);
    write_reg(CFG_LEFT_SCALE, 32'd0);
    write_reg(CFG_TRACK, 32'd0);
    write_reg(CFG_LEFT_REV, 32'd1);
    send_item(sample(1, 64'd1040, 64'd9020));
    send_item(sample(1, 64'd2040, 64'd7020));
    drain();
    write_reg(CFG_LEFT_SCALE, 32'd65536);
    write_reg(CFG_RIGHT_REV, 32'd1);
    write_reg(CFG_TRACK, 32'd13107200);
    write_reg(CFG_PERIOD, 32'd1000);
    send_item(sample(1, 64'd3040, 64'd7520));
    drain();
  endtask

  task automatic random_item;
    int          k;
    logic [63:0] dl, dr;
    k = $urandom_range(0, 99);
    if (k < 4) begin
      send_item(pose($urandom, $urandom, $urandom));
    end else if (k < 10) begin
      send_item(sample(0, {$urandom, $urandom}, {$urandom, $urandom}));
    end else if (k < 14) begin
      cur_l = {$urandom, $urandom};
      cur_r = {$urandom, $urandom};
      send_item(sample(1, cur_l, cur_r));
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        dl = {{32{1'b0}}, $urandom} - 64'h8000_0000;
        dr = {{32{1'b0}}, $urandom} - 64'h8000_0000;
      end else begin
        dl = 64'($urandom_range(0, 10000)) - 64'd5000;
        dr = 64'($urandom_range(0, 10000)) - 64'd5000;
      end
      cur_l += dl;
      cur_r += dr;
      send_item(sample(1, cur_l, cur_r));
    end
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CFG_LEFT_SCALE, pick_scale());
      write_reg(CFG_RIGHT_SCALE, pick_scale());
      write_reg(CFG_LEFT_REV, $urandom_range(0, 1));
      write_reg(CFG_RIGHT_REV, $urandom_range(0, 1));
      case (ph)
        0: write_reg(CFG_TRACK, 32'd1);
        1: write_reg(CFG_TRACK, 32'hFFFFFFFF);
        default: write_reg(CFG_TRACK, $urandom_range(32'h0001_0000, 32'h4000_0000));
      endcase
      case (ph)
        0: write_reg(CFG_PERIOD, 32'd1);
        1: write_reg(CFG_PERIOD, 32'd1000);
        default: write_reg(CFG_PERIOD, $urandom_range(1, 1000));
      endcase
      idle_on = (ph < 4);
      repeat (290) random_item();
    end
  endtask

  task automatic test_backpressure;
    drain();
    hold_cycles = 400;
    repeat (6) send_item(pose($urandom, $urandom, $urandom));
    send_item(sample(1, cur_l, cur_r));
    drain();
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_item = '0;
    cfg_valid = 0;
    cfg_index = CFG_LEFT_SCALE;
    cfg_data = 0;
    mismatches = 0;
    n_items = 0;
    n_results = 0;
    n_integrated = 0;
    n_cfg = 0;
    idle_on = 1;
    hold_cycles = 0;
    cur_l = 0;
    cur_r = 0;
    lscale = 32'd65536;
    rscale = 32'd65536;
    lrev = 0;
    rrev = 0;
    track = 32'd13107200;
    period = 32'd10;
    base_seen = 0;
    base_l = 0;
    base_r = 0;
    elapsed = 0;
    pose_x = 0;
    pose_y = 0;
    yaw = 0;
    speed_q = 0;
    rate_q = 0;
    mode_q = MODE_IDLE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d integrated moves, %0d register writes.",
             n_items, n_results, n_integrated, n_cfg);
    $display("Mismatches: %0d, results still owed: %0d", mismatches, expected_pose_q.size());
    if (mismatches == 0 && expected_pose_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ddo_pkg.sv
design/ddo_mul.sv
design/ddo_div.sv
design/ddo_cordic.sv
design/diff_drive_odometry_unit.sv
tb/diff_drive_odometry_unit_test.sv
